>>> rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg - shared types and constants for the 3x3 box blur
// Sizes, register indexes, reset values, window and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  // frame dimensions and incremented counters, wide enough to hold the maximum
  localparam int DIM_W    = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
  // input line count runs ahead of the output by one line and one word
  localparam int IN_ROW_W = DIM_W + 1;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd800;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd600;

  // operation codes of an input word
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int WORD_W = 32;
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int R_LSB  = 16;
  localparam int G_LSB  = 8;
  localparam int B_LSB  = 0;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  localparam int WIN_COLS = 3;
  localparam int CSUM_W   = CH_W + 2;   // three channel values
  localparam int TSUM_W   = CH_W + 4;   // nine channel values

  // x / 9 == (x * 7282) >> 16 for every x up to 9 * 255
  localparam int DIV9_MUL_W = 13;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
  localparam int DIV9_SHIFT = 16;
  localparam int PROD_W     = TSUM_W + DIV9_MUL_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    logic [CSUM_W-1:0] r;
    logic [CSUM_W-1:0] g;
    logic [CSUM_W-1:0] b;
  } chan_sum_t;

  typedef struct packed {
    logic emit;
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
    logic last;
  } meta_t;

  typedef struct packed {
    logic col_ok;
    logic top_ok;
    logic bot_ok;
  } mask_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            last;
  } result_t;

endpackage

>>> rtl/box_blur_3x3_rgb_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit - 3x3 box blur over a raster RGBA8888 stream
// Throughput: one word per cycle in and out while the queue has credit and the
// receiver is ready; the line stores take one read and one write per cycle and
// the window advances with every accepted word. A result passes the line store
// read, window, column sum and total registers into the queue, one line plus
// one word after its own pixel. Reset clears counters, pipeline and queue,
// sets 800x600; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_3x3_rgb_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [bb3_pkg::WORD_W-1:0]    pixel_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bb3_pkg::CH_W-1:0]      blurred_red,
  output logic [bb3_pkg::CH_W-1:0]      blurred_green,
  output logic [bb3_pkg::CH_W-1:0]      blurred_blue,
  output logic [bb3_pkg::CH_W-1:0]      alpha_out,
  output logic                          frame_end
);
  import bb3_pkg::*;

  logic [CFG_W-1:0]    frame_width;
  logic [CFG_W-1:0]    frame_height;
  logic [DIM_W-1:0]    w;
  logic [DIM_W-1:0]    h;

  logic [COL_W-1:0]    in_col;
  logic [IN_ROW_W-1:0] in_row;
  logic [COL_W-1:0]    out_col;
  logic [ROW_W-1:0]    out_row;
  logic [COL_W-1:0]    in_col_next;
  logic [IN_ROW_W-1:0] in_row_next;
  logic [COL_W-1:0]    out_col_next;
  logic [ROW_W-1:0]    out_row_next;
  logic [DIM_W-1:0]    ic_inc;
  logic [DIM_W-1:0]    oc_inc;
  logic [DIM_W-1:0]    or_inc;

  logic                in_fire;
  logic                out_fire;
  logic                in_frame;
  logic                s0_active;
  pix_t                s0_val;
  meta_t               s0_meta;

  logic                s1_valid;
  logic [COL_W-1:0]    s1_slot;
  pix_t                s1_val;
  meta_t               s1_meta;
  logic                s2_emit;
  meta_t               s2_meta;
  logic                s3_emit;
  logic                s3_last;

  pix_t                lb_top;
  pix_t                lb_mid;
  column_t             col_in [WIN_COLS];
  column_t             col_q  [WIN_COLS];
  mask_t               col_mask [WIN_COLS];
  chan_sum_t           csum [WIN_COLS];

  logic                push;
  result_t             push_data;
  result_t             head;
  logic [CNT_W-1:0]    credit;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (frame_width == '0) begin
      w = DIM_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = DIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      h = DIM_W'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = DIM_W'(frame_height);
    end
  end

  assign in_ready = (credit < CNT_W'(FIFO_DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // a flush word while the frame is still coming in is dropped
  assign in_frame  = (in_row < IN_ROW_W'(h));
  assign s0_active = in_fire && !(in_frame && (operation == OP_FLUSH));
  assign s0_val    = in_frame ? pixel_word[WORD_W-1 -: PIX_W] : '0;

  assign ic_inc = DIM_W'(in_col) + 1'b1;
  assign oc_inc = DIM_W'(out_col) + 1'b1;
  assign or_inc = DIM_W'(out_row) + 1'b1;

  always_comb begin
    s0_meta.emit     = (in_row >= IN_ROW_W'(2))
                    || ((in_row == IN_ROW_W'(1)) && (in_col != '0));
    s0_meta.left_ok  = (out_col != '0);
    s0_meta.right_ok = (oc_inc < w);
    s0_meta.top_ok   = (out_row != '0);
    s0_meta.bot_ok   = (or_inc < h);
    s0_meta.last     = !s0_meta.right_ok && !s0_meta.bot_ok;
  end

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (s0_active) begin
      if (ic_inc >= w) begin
        in_col_next = '0;
        in_row_next = in_row + 1'b1;
      end else begin
        in_col_next = COL_W'(ic_inc);
      end
      if (s0_meta.emit) begin
        if (s0_meta.last) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end else if (oc_inc >= w) begin
          out_col_next = '0;
          out_row_next = ROW_W'(or_inc);
        end else begin
          out_col_next = COL_W'(oc_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // pipeline control: valid bits reset, payload does not
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_emit  <= 1'b0;
      s3_emit  <= 1'b0;
    end else begin
      s1_valid <= s0_active;
      s2_emit  <= s1_valid && s1_meta.emit;
      s3_emit  <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_slot <= in_col;
    s1_val  <= s0_val;
    s1_meta <= s0_meta;
    s2_meta <= s1_meta;
    s3_last <= s2_meta.last;
  end

  bb3_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s0_active),
    .rd_addr (in_col),
    .wr_en   (s1_valid),
    .wr_addr (s1_slot),
    .wr_val  (s1_val),
    .top     (lb_top),
    .mid     (lb_mid)
  );

  // window: new column enters on the right, columns move left
  for (genvar k = 0; k < WIN_COLS; k++) begin : g_win
    if (k == WIN_COLS - 1) begin : g_right
      assign col_in[k].top    = lb_top;
      assign col_in[k].mid    = lb_mid;
      assign col_in[k].bot    = s1_val;
      assign col_mask[k].col_ok = s2_meta.right_ok;
    end else if (k == 0) begin : g_left
      assign col_in[k]          = col_q[k+1];
      assign col_mask[k].col_ok = s2_meta.left_ok;
    end else begin : g_mid
      assign col_in[k]          = col_q[k+1];
      assign col_mask[k].col_ok = 1'b1;
    end
    assign col_mask[k].top_ok = s2_meta.top_ok;
    assign col_mask[k].bot_ok = s2_meta.bot_ok;

    bb3_cell u_cell (
      .clk    (clk),
      .shift  (s1_valid),
      .col_in (col_in[k]),
      .mask   (col_mask[k]),
      .col_q  (col_q[k]),
      .csum   (csum[k])
    );
  end

  bb3_div9 u_div9 (
    .clk       (clk),
    .rst       (rst),
    .in_emit   (s3_emit),
    .in_last   (s3_last),
    .csum      (csum),
    .push      (push),
    .push_data (push_data)
  );

  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (out_fire),
    .valid     (out_valid),
    .head      (head)
  );

  // count words in the pipeline and the queue; hold input when all are taken
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      case ({s0_active && s0_meta.emit, out_fire})
        2'b10:   credit <= credit + 1'b1;
        2'b01:   credit <= credit - 1'b1;
        default: credit <= credit;
      endcase
    end
  end

  assign blurred_red   = head.r;
  assign blurred_green = head.g;
  assign blurred_blue  = head.b;
  assign alpha_out     = ALPHA_OPAQUE;
  assign frame_end     = head.last;

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CNT_W'(FIFO_DEPTH))
    else $error("credit count beyond queue depth");

  a_valid_has_credit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (credit != '0))
    else $error("result word without a credit");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (s0_active && s0_meta.emit && s0_meta.last) |=>
      ((in_col == '0) && (in_row == '0) && (out_col == '0) && (out_row == '0)))
    else $error("counters not cleared after frame end");
`endif

endmodule

>>> rtl/bb3_line_buf.sv
// ----------------------------------------------------------------------------
// bb3_line_buf - upper and middle line stores
// One read and one write per cycle on each store, registered read data,
// with a bypass for a read that meets a write to the same column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_line_buf (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [bb3_pkg::COL_W-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [bb3_pkg::COL_W-1:0] wr_addr,
  input  bb3_pkg::pix_t            wr_val,
  output bb3_pkg::pix_t            top,
  output bb3_pkg::pix_t            mid
);
  import bb3_pkg::*;

  pix_t upper_mem  [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t upper_q;
  pix_t middle_q;
  logic fwd;
  pix_t fwd_top;
  pix_t fwd_mid;

  // the write of the previous column lands on the same edge as the read
  assign top = fwd ? fwd_top : upper_q;
  assign mid = fwd ? fwd_mid : middle_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q  <= upper_mem[rd_addr];
      middle_q <= middle_mem[rd_addr];
      fwd_top  <= mid;
      fwd_mid  <= wr_val;
    end
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid;
      middle_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

endmodule

>>> rtl/bb3_cell.sv
// ----------------------------------------------------------------------------
// bb3_cell - one column of the 3x3 window
// Holds three pixels, passes them on at each shift and registers the
// masked per-channel column sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_cell (
  input  logic               clk,
  input  logic               shift,
  input  bb3_pkg::column_t   col_in,
  input  bb3_pkg::mask_t     mask,
  output bb3_pkg::column_t   col_q,
  output bb3_pkg::chan_sum_t csum
);
  import bb3_pkg::*;

  pix_t      t;
  pix_t      m;
  pix_t      b;
  chan_sum_t csum_next;

  always_comb begin
    t = (mask.col_ok && mask.top_ok) ? col_q.top : '0;
    m = mask.col_ok ? col_q.mid : '0;
    b = (mask.col_ok && mask.bot_ok) ? col_q.bot : '0;
    csum_next.r = CSUM_W'(t[R_LSB +: CH_W]) + CSUM_W'(m[R_LSB +: CH_W])
                + CSUM_W'(b[R_LSB +: CH_W]);
    csum_next.g = CSUM_W'(t[G_LSB +: CH_W]) + CSUM_W'(m[G_LSB +: CH_W])
                + CSUM_W'(b[G_LSB +: CH_W]);
    csum_next.b = CSUM_W'(t[B_LSB +: CH_W]) + CSUM_W'(m[B_LSB +: CH_W])
                + CSUM_W'(b[B_LSB +: CH_W]);
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
    csum <= csum_next;
  end

endmodule

>>> rtl/bb3_div9.sv
// ----------------------------------------------------------------------------
// bb3_div9 - window total and divide by nine
// Adds the three column sums, then divides by a reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_div9 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_emit,
  input  logic               in_last,
  input  bb3_pkg::chan_sum_t csum [bb3_pkg::WIN_COLS],
  output logic               push,
  output bb3_pkg::result_t   push_data
);
  import bb3_pkg::*;

  logic [TSUM_W-1:0] sum_r;
  logic [TSUM_W-1:0] sum_g;
  logic [TSUM_W-1:0] sum_b;
  logic [TSUM_W-1:0] tot_r;
  logic [TSUM_W-1:0] tot_g;
  logic [TSUM_W-1:0] tot_b;
  logic              emit_q;
  logic              last_q;

  function automatic logic [CH_W-1:0] div9(input logic [TSUM_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(DIV9_MUL);
    return p[DIV9_SHIFT +: CH_W];
  endfunction

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < WIN_COLS; k++) begin
      sum_r = sum_r + TSUM_W'(csum[k].r);
      sum_g = sum_g + TSUM_W'(csum[k].g);
      sum_b = sum_b + TSUM_W'(csum[k].b);
    end
  end

  always_ff @(posedge clk) begin
    tot_r  <= sum_r;
    tot_g  <= sum_g;
    tot_b  <= sum_b;
    last_q <= in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_q <= 1'b0;
    end else begin
      emit_q <= in_emit;
    end
  end

  assign push           = emit_q;
  assign push_data.r    = div9(tot_r);
  assign push_data.g    = div9(tot_g);
  assign push_data.b    = div9(tot_b);
  assign push_data.last = last_q;

endmodule

>>> rtl/bb3_out_fifo.sv
// ----------------------------------------------------------------------------
// bb3_out_fifo - result queue
// Small queue between the blur pipeline and the output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bb3_pkg::result_t push_data,
  input  logic             pop,
  output logic             valid,
  output bb3_pkg::result_t head
);
  import bb3_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [CNT_W-1:0]   count;

  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(FIFO_DEPTH)))
    else $error("result queue written while full");
`endif

endmodule

>>> tb/box_blur_3x3_rgb_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit_test - self-checking bench for the 3x3 box blur
// Streams frames of RGBA words through the unit under bursty input and a
// stalling output, predicts every blurred word from its own copy of the line
// stores and window, and compares each result in order. Covers clamped frame
// sizes, ignored flushes, dropped drain pixels and size changes mid-frame.
// ----------------------------------------------------------------------------

module box_blur_3x3_rgb_unit_test;
  import bb3_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_WORDS  = 150;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last;
  } blur_word_t;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 operation  = OP_PIXEL;
  logic [WORD_W-1:0]    pixel_word = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [CH_W-1:0]      blurred_red;
  logic [CH_W-1:0]      blurred_green;
  logic [CH_W-1:0]      blurred_blue;
  logic [CH_W-1:0]      alpha_out;
  logic                 frame_end;

  // predicted copy of the unit
  logic [CFG_W-1:0] width_reg_q  = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg_q = FRAME_HEIGHT_RST;
  pix_t             upper_line  [MAX_WIDTH];
  pix_t             middle_line [MAX_WIDTH];
  pix_t             window_px   [9];   // column * 3 + row, column 0 left, row 0 top
  int unsigned      in_col, in_row, out_col, out_row;

  blur_word_t  blurred_q[$];
  int unsigned burst_left     = 0;
  int unsigned words_sent     = 0;
  int unsigned ignored_words  = 0;
  int unsigned results_seen   = 0;
  int unsigned frames_done    = 0;
  int unsigned fault_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  int unsigned stall_mode     = 0;

  box_blur_3x3_rgb_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .pixel_word    (pixel_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .blurred_red   (blurred_red),
    .blurred_green (blurred_green),
    .blurred_blue  (blurred_blue),
    .alpha_out     (alpha_out),
    .frame_end     (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: switch at random between stall patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_left % 9) < 3);
    endcase
  end

  always @(posedge clk) begin : result_check
    blur_word_t got;
    blur_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = {blurred_red, blurred_green, blurred_blue, alpha_out, frame_end};
      results_seen++;
      if (got.last) frames_done++;
      if (blurred_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected word r=%02h g=%02h b=%02h a=%02h end=%0b",
                   got.red, got.green, got.blue, got.alpha, got.last);
      end else begin
        want = blurred_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.last !== want.last) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display({"word %0d: expected r=%02h g=%02h b=%02h a=%02h end=%0b, ",
                      "got r=%02h g=%02h b=%02h a=%02h end=%0b"},
                     results_seen, want.red, want.green, want.blue, want.alpha,
                     want.last, got.red, got.green, got.blue, got.alpha, got.last);
        end
      end
    end
  end

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] raw, input int unsigned limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return 32'(raw);
  endfunction

  task automatic blur_predict(input logic op, input logic [WORD_W-1:0] word);
    int unsigned w, h, slot, sr, sg, sb, i, c, r;
    pix_t        val, top, mid, p;
    bit          emit, last;
    blur_word_t  res;
    w  = eff_dim(width_reg_q, MAX_WIDTH);
    h  = eff_dim(height_reg_q, MAX_HEIGHT);
    sr = 0;
    sg = 0;
    sb = 0;
    if (in_row < h && op == OP_FLUSH) begin
      // flush while the frame is still coming in: drop it
      ignored_words++;
    end else begin
      val  = (in_row < h) ? word[WORD_W-1 -: PIX_W] : '0;
      slot = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
      top  = upper_line[slot];
      mid  = middle_line[slot];
      upper_line[slot]  = mid;
      middle_line[slot] = val;
      for (i = 0; i < 6; i++) window_px[i] = window_px[i + 3];
      window_px[6] = top;
      window_px[7] = mid;
      window_px[8] = val;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (emit) begin
        for (c = 0; c < 3; c++) begin
          for (r = 0; r < 3; r++) begin
            if (!((c == 0 && out_col < 1) || (c == 2 && out_col + 1 >= w) ||
                  (r == 0 && out_row < 1) || (r == 2 && out_row + 1 >= h))) begin
              p  = window_px[c * 3 + r];
              sr += 32'(p[R_LSB +: CH_W]);
              sg += 32'(p[G_LSB +: CH_W]);
              sb += 32'(p[B_LSB +: CH_W]);
            end
          end
        end
        last      = (out_row + 1 >= h) && (out_col + 1 >= w);
        res.red   = CH_W'(sr / 9);
        res.green = CH_W'(sg / 9);
        res.blue  = CH_W'(sb / 9);
        res.alpha = ALPHA_OPAQUE;
        res.last  = last;
        blurred_q.push_back(res);
        if (last) begin
          in_col  = 0;
          in_row  = 0;
          out_col = 0;
          out_row = 0;
        end else begin
          out_col++;
          if (out_col >= w) begin
            out_col = 0;
            out_row++;
          end
        end
      end
    end
  endtask

  task automatic send_word(input logic op, input logic [WORD_W-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    operation  <= op;
    pixel_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    blur_predict(op, word);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg_q = value;
    else height_reg_q = value;
  endtask

  task automatic set_frame_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // feed pixels then flushes until the frame closes; noise_pct of the words
  // are the wrong kind for the phase (ignored flushes, dropped pixels)
  task automatic run_frame(input bit resume, input int unsigned noise_pct);
    bit   started;
    logic op;
    started = resume;
    while (!started || in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0) begin
      if (in_row < eff_dim(height_reg_q, MAX_HEIGHT))
        op = ($urandom_range(0, 99) < noise_pct) ? OP_FLUSH : OP_PIXEL;
      else
        op = ($urandom_range(0, 99) < noise_pct) ? OP_PIXEL : OP_FLUSH;
      if (op == OP_PIXEL) started = 1'b1;
      send_word(op, $urandom);
    end
  endtask

  task automatic sized_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    set_frame_dims(w, h);
    run_frame(1'b0, 5);
    wait_for_drain();
  endtask

  task automatic mid_frame_case(input logic [CFG_W-1:0] w0, input logic [CFG_W-1:0] h0,
                                input int unsigned n, input logic [CFG_W-1:0] w1,
                                input logic [CFG_W-1:0] h1);
    set_frame_dims(w0, h0);
    repeat (n) send_word(OP_PIXEL, $urandom);
    wait_for_drain();
    set_frame_dims(w1, h1);
    run_frame(1'b1, 10);
    wait_for_drain();
  endtask

  task automatic test_edge_pixels();
    int unsigned k;
    set_frame_dims(11'd3, 11'd3);
    send_word(OP_PIXEL, 32'hFFFFFF00);
    send_word(OP_PIXEL, 32'h000000FF);
    send_word(OP_PIXEL, 32'hFF0000AA);
    send_word(OP_PIXEL, 32'h00FF0055);
    // flush while the frame is still coming in
    send_word(OP_FLUSH, 32'hFFFFFFFF);
    send_word(OP_PIXEL, 32'h0000FF00);
    send_word(OP_PIXEL, 32'hFFFFFFFF);
    send_word(OP_PIXEL, 32'h00000000);
    send_word(OP_PIXEL, 32'h80808080);
    send_word(OP_PIXEL, 32'h7F7F7F7F);
    // pixel after the frame is in counts as a flush tick
    send_word(OP_PIXEL, 32'hFFFFFFFF);
    repeat (3) send_word(OP_FLUSH, 32'h00000000);
    wait_for_drain();
    // all-white frame: the centre sums to exactly 9 * 255
    for (k = 0; k < 9; k++) send_word(OP_PIXEL, {24'hFFFFFF, 8'(k * 29)});
    repeat (4) send_word(OP_FLUSH, 32'hFFFFFFFF);
    wait_for_drain();
  endtask

  task automatic test_register_limits();
    sized_frame(11'd0, 11'd0);
    sized_frame(11'd0, 11'd3);
    sized_frame(11'd4, 11'd0);
    sized_frame(11'd1, 11'd5);
    sized_frame(11'd5, 11'd1);
    sized_frame(11'd5, 11'd3);
  endtask

  task automatic test_mid_frame_change();
    // shrink width below the running column counters
    mid_frame_case(11'd8, 11'd6, 30, 11'd5, 11'd4);
    // grow both sizes early in the frame
    mid_frame_case(11'd4, 11'd3, 5, 11'd12, 11'd7);
    // cut the height below the line already reached
    mid_frame_case(11'd6, 11'd8, 30, 11'd6, 11'd2);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    start = words_sent - ignored_words;
    while (words_sent - ignored_words - start < RANDOM_WORDS) begin
      // half the frames run back to back at the same size
      if ($urandom_range(0, 1) == 0) begin
        wait_for_drain();
        set_frame_dims(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)));
      end
      run_frame(1'b0, 10);
    end
    wait_for_drain();
  endtask

  initial begin
    int k;
    for (k = 0; k < MAX_WIDTH; k++) begin
      upper_line[k]  = '0;
      middle_line[k] = '0;
    end
    for (k = 0; k < 9; k++) window_px[k] = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_pixels();
    test_register_limits();
    test_mid_frame_change();
    test_random_frames();

    wait_for_drain();
    if (blurred_q.size() != 0) begin
      fault_count++;
      $display("%0d expected words never arrived", blurred_q.size());
    end
    $display("%0d words in (%0d flushes ignored), %0d blurred words checked over %0d frames",
             words_sent, ignored_words, results_seen, frames_done);
    $display("frames from 1x1 to 12x8, zero-sized registers, resized frames, bursty flow");
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d faults", fault_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
